// ===== rtl/brsm_pkg.sv =====
// Package for the block reference-count space map.
// Holds command and status codes; no dependencies.
package brsm_pkg;

  typedef enum logic [2:0] {
    CMD_GET  = 3'd0,
    CMD_SET  = 3'd1,
    CMD_INC  = 3'd2,
    CMD_DEC  = 3'd3,
    CMD_FIND = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  localparam logic [1:0] CODE_OVF = 2'b11;

endpackage

// ===== rtl/brsm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module brsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/block_refcount_space_map.sv =====
// Top level of the block reference-count space map.
// Uses brsm_pkg and brsm_ram (code words, overflow keys, overflow counts).
//
// Channel  Dir  tdata fields (low bit first)                        tuser
// in_      in   cmd[2:0] block_addr[14:3] amount[46:15] span_end[59:47]  -
// out_     out  status[1:0] count_out[33:2] found[34] free_block[46:35]
//               free_total[59:47]                                      -
// cfg_     in   block_count (13 bits)
//
// A get reads its code word (S_RD, S_CODE) and answers via S_CALC and S_OUT;
// set, inc and dec also pass S_FREE and S_WR. An overflowed count adds a key
// search (S_OSRCH, S_ORD per key, up to OVERFLOW_DEPTH keys) and S_OCNT. A
// free-block search reads and checks each block (S_FRD, S_FCHK). After reset
// a clear over max(words, OVERFLOW_DEPTH) entries runs first. The result sits in
// an output register; the next input is accepted in the cycle after it is taken.
module block_refcount_space_map #(
  parameter int MAX_BLOCKS     = 4096,
  parameter int OVERFLOW_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // cmd, block_addr, amount, span_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // status, count_out, found, free_block, free_total
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata   // block_count
);
  import brsm_pkg::*;

  localparam int WORDS = MAX_BLOCKS / 32;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OAW   = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
  localparam int CLRN  = (WORDS > OVERFLOW_DEPTH) ? WORDS : OVERFLOW_DEPTH;
  localparam int CLW   = $clog2(CLRN + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CODE, S_OSRCH, S_ORD, S_OCNT, S_CALC, S_FREE,
    S_WR, S_FRD, S_FCHK, S_OUT
  } state_t;

  state_t state_r;
  logic [CLW-1:0] clr_r;
  logic [12:0] bc_r, used_r;
  logic [11:0] floor_r;
  logic [2:0]  cmd_r;
  logic [11:0] addr_r;
  logic [31:0] amt_r, old_r, nc_r;
  logic [12:0] end_r, scan_r;
  logic [OAW-1:0] oidx_r;
  logic [OAW:0]   ocnt_r;
  logic        ohit_r;
  logic [63:0] word_r;
  logic [OVERFLOW_DEPTH-1:0] ovalid_r;
  logic [1:0]  st_r;
  logic [31:0] cnt_r;
  logic        fnd_r;
  logic [11:0] fb_r;

  // Memories.
  logic            cw_we, ok_we, oc_we;
  logic [WAW-1:0]  cw_waddr, cw_raddr;
  logic [63:0]     cw_wdata, cw_rdata;
  logic [OAW-1:0]  ok_waddr, ok_raddr, oc_waddr;
  logic [12:0]     ok_wdata, ok_rdata;
  logic [31:0]     oc_wdata, oc_rdata;

  brsm_ram #(.WIDTH(64), .DEPTH(WORDS)) u_codes (
    .clk, .we(cw_we), .waddr(cw_waddr), .wdata(cw_wdata),
    .raddr(cw_raddr), .rdata(cw_rdata));
  brsm_ram #(.WIDTH(13), .DEPTH(OVERFLOW_DEPTH)) u_okeys (
    .clk, .we(ok_we), .waddr(ok_waddr), .wdata(ok_wdata),
    .raddr(ok_raddr), .rdata(ok_rdata));
  brsm_ram #(.WIDTH(32), .DEPTH(OVERFLOW_DEPTH)) u_ocnts (
    .clk, .we(oc_we), .waddr(oc_waddr), .wdata(oc_wdata),
    .raddr(oidx_r), .rdata(oc_rdata));

  logic [11:0] baddr;
  logic [4:0]  slot;
  logic [1:0]  ncode;
  logic        in_acc;
  logic [OAW-1:0] free_idx;
  logic        free_any;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign baddr     = (state_r == S_FRD || state_r == S_FCHK) ? scan_r[11:0] : addr_r;
  assign slot      = baddr[4:0];
  assign ncode     = (nc_r > 32'd2) ? CODE_OVF : nc_r[1:0];

  // Lowest free overflow slot by priority encode of valid bits.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = OVERFLOW_DEPTH - 1; i >= 0; i--) begin
      if (!ovalid_r[i]) begin
        free_idx = OAW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    cw_raddr = WAW'(baddr >> 5);
    ok_raddr = oidx_r;
    cw_we = 1'b0; cw_waddr = WAW'(addr_r >> 5); cw_wdata = word_r;
    ok_we = 1'b0; ok_waddr = oidx_r; ok_wdata = {1'b0, addr_r};
    oc_we = 1'b0; oc_waddr = oidx_r; oc_wdata = nc_r;
    if (state_r == S_CLEAR) begin
      cw_we    = (clr_r < CLW'(WORDS));
      cw_waddr = clr_r[WAW-1:0];
      cw_wdata = '0;
    end else if (state_r == S_WR) begin
      cw_we = 1'b1;
      cw_wdata = word_r & ~(64'd3 << {slot, 1'b0})
               | (64'(ncode) << {slot, 1'b0});
      if (nc_r > 32'd2) begin
        ok_we = 1'b1;
        oc_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      bc_r       <= 13'(MAX_BLOCKS);
      used_r     <= '0;
      floor_r    <= '0;
      ovalid_r   <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        bc_r <= (cfg_wdata > 13'(MAX_BLOCKS)) ? 13'(MAX_BLOCKS) : cfg_wdata;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLW'(CLRN - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_r  <= in_tdata[2:0];
            addr_r <= in_tdata[14:3];
            amt_r  <= in_tdata[46:15];
            end_r  <= in_tdata[59:47];
            scan_r <= (13'(floor_r) > {1'b0, in_tdata[14:3]}) ?
                      13'(floor_r) : {1'b0, in_tdata[14:3]};
            st_r <= ST_OK; cnt_r <= '0; fnd_r <= 1'b0; fb_r <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (cmd_r == CMD_FIND) state_r <= S_FRD;
          else if (cmd_r > CMD_FIND) state_r <= S_OUT;
          else if ({1'b0, addr_r} >= bc_r) begin
            st_r <= ST_BOUNDS; state_r <= S_OUT;
          end else state_r <= S_CODE;
        end
        S_CODE: begin
          word_r <= cw_rdata;
          old_r  <= 32'(cw_rdata[{slot, 1'b0} +: 2]);
          oidx_r <= '0;
          ocnt_r <= '0;
          ohit_r <= 1'b0;
          state_r <= (cw_rdata[{slot, 1'b0} +: 2] == CODE_OVF) ? S_OSRCH : S_CALC;
        end
        // Overflow key search: each key is read in S_OSRCH and compared in S_ORD.
        S_OSRCH: state_r <= S_ORD;
        S_ORD: begin
          if (ovalid_r[oidx_r] && ok_rdata == {1'b0, addr_r}) begin
            ohit_r <= 1'b1; state_r <= S_OCNT;
          end else if (ocnt_r == (OAW+1)'(OVERFLOW_DEPTH - 1)) begin
            st_r <= ST_MISSING; state_r <= S_OUT;
          end else begin
            oidx_r <= oidx_r + 1'b1;
            ocnt_r <= ocnt_r + 1'b1;
            state_r <= S_OSRCH;
          end
        end
        S_OCNT: begin
          old_r <= oc_rdata;
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (cmd_r == CMD_GET) begin
            cnt_r <= old_r; state_r <= S_OUT;
          end else begin
            unique case (cmd_r)
              CMD_SET: nc_r <= amt_r;
              CMD_INC: nc_r <= old_r + amt_r;
              default: nc_r <= old_r - amt_r;
            endcase
            state_r <= S_FREE;
          end
        end
        S_FREE: begin
          if (nc_r > 32'd2 && !ohit_r) begin
            if (!free_any) begin
              st_r <= ST_FULL; cnt_r <= old_r; state_r <= S_OUT;
            end else begin
              oidx_r <= free_idx; state_r <= S_WR;
            end
          end else state_r <= S_WR;
        end
        S_WR: begin
          if (nc_r > 32'd2) ovalid_r[oidx_r] <= 1'b1;
          else if (ohit_r) ovalid_r[oidx_r] <= 1'b0;
          if (old_r == 32'd0 && nc_r != 32'd0) used_r <= used_r + 1'b1;
          else if (old_r != 32'd0 && nc_r == 32'd0) begin
            if (addr_r < floor_r) floor_r <= addr_r;
            if (used_r != 13'd0) used_r <= used_r - 1'b1;
          end
          cnt_r <= nc_r;
          state_r <= S_OUT;
        end
        S_FRD: begin
          if (scan_r >= end_r) state_r <= S_OUT;
          else if (scan_r >= bc_r) begin
            st_r <= ST_BOUNDS; state_r <= S_OUT;
          end else state_r <= S_FCHK;
        end
        S_FCHK: begin
          // Code 3 always has an entry in normal operation; its count is > 2.
          if (cw_rdata[{slot, 1'b0} +: 2] == 2'd0) begin
            fnd_r <= 1'b1; fb_r <= scan_r[11:0]; state_r <= S_OUT;
          end else begin
            scan_r <= scan_r + 1'b1; state_r <= S_FRD;
          end
        end
        S_OUT: begin
          if (!out_tvalid) begin
            out_tvalid <= 1'b1;
            out_tdata  <= {4'd0, ((bc_r > used_r) ? bc_r - used_r : 13'd0),
                           fb_r, fnd_r, cnt_r, st_r};
          end else if (out_tready) begin
            out_tvalid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for block_refcount_space_map.
// Drives command transactions under random back-pressure and compares each result
// with a behavioral model of the reference-count store. Depends on brsm_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import brsm_pkg::*;

  localparam int NBLK = 4096;
  localparam int OVF_DEPTH = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count;
    logic        found;
    logic [11:0] free_block;
    logic [12:0] free_total;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  block_refcount_space_map u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Model state.
  logic [1:0]  m_code [NBLK];
  logic        m_ovf_vld [OVF_DEPTH];
  logic [11:0] m_ovf_key [OVF_DEPTH];
  logic [31:0] m_ovf_cnt [OVF_DEPTH];
  int unsigned m_used;
  int unsigned m_floor;
  int unsigned m_blocks;

  result_t expected_q[$];
  int mismatches = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_cycles = 0;

  function automatic int ovf_lookup(int unsigned b);
    for (int i = 0; i < OVF_DEPTH; i++)
      if (m_ovf_vld[i] && m_ovf_key[i] == b[11:0]) return i;
    return -1;
  endfunction

  // Reads a count; returns 0 if the code says overflow but no entry exists.
  function automatic bit read_count(int unsigned b, output logic [31:0] c);
    int i;
    if (m_code[b] != CODE_OVF) begin
      c = 32'(m_code[b]);
      return 1'b1;
    end
    i = ovf_lookup(b);
    c = (i < 0) ? 32'd0 : m_ovf_cnt[i];
    return i >= 0;
  endfunction

  function automatic status_t write_count(int unsigned b, logic [31:0] old, logic [31:0] c);
    int i;
    if (old > 2) begin
      i = ovf_lookup(b);
      if (i < 0) return ST_MISSING;
      if (c > 2) m_ovf_cnt[i] = c;
      else begin
        m_ovf_vld[i] = 1'b0;
        m_code[b] = c[1:0];
      end
    end else if (c > 2) begin
      for (i = 0; i < OVF_DEPTH; i++) if (!m_ovf_vld[i]) break;
      if (i >= OVF_DEPTH) return ST_FULL;
      m_ovf_vld[i] = 1'b1;
      m_ovf_key[i] = b[11:0];
      m_ovf_cnt[i] = c;
      m_code[b] = CODE_OVF;
    end else begin
      m_code[b] = c[1:0];
    end
    if (old == 0 && c != 0) m_used++;
    else if (old != 0 && c == 0) begin
      if (b < m_floor) m_floor = b;
      if (m_used > 0) m_used--;
    end
    return ST_OK;
  endfunction

  function automatic result_t predict_refcount(logic [2:0] cmd, logic [11:0] addr,
                                               logic [31:0] amt, logic [12:0] span_end);
    result_t r;
    logic [31:0] old, c, nc;
    int unsigned a;
    status_t st;
    r = '0;
    if (cmd == CMD_FIND) begin
      a = (m_floor > addr) ? m_floor : addr;
      for (; a < span_end; a++) begin
        if (a >= m_blocks) begin
          r.status = ST_BOUNDS;
          break;
        end
        if (!read_count(a, c)) begin
          r.status = ST_MISSING;
          break;
        end
        if (c == 0) begin
          r.found = 1'b1;
          r.free_block = a[11:0];
          break;
        end
      end
    end else if (cmd <= CMD_DEC) begin
      if (addr >= m_blocks) r.status = ST_BOUNDS;
      else if (!read_count(addr, old)) r.status = ST_MISSING;
      else if (cmd == CMD_GET) r.count = old;
      else begin
        if (cmd == CMD_SET) nc = amt;
        else if (cmd == CMD_INC) nc = old + amt;
        else nc = old - amt;
        st = write_count(addr, old, nc);
        r.status = st;
        r.count = (st == ST_OK) ? nc : (st == ST_FULL) ? old : 32'd0;
      end
    end
    r.free_total = (m_blocks > m_used) ? 13'(m_blocks - m_used) : 13'd0;
    return r;
  endfunction

  // Leaves in_tvalid high after acceptance so transactions can run back to back.
  task automatic send_cmd(logic [2:0] cmd, logic [11:0] addr, logic [31:0] amt,
                          logic [12:0] span_end);
    if (in_idle_pct > 0 && $urandom_range(99, 0) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < in_idle_pct) @(posedge clk);
    end
    expected_q.push_back(predict_refcount(cmd, addr, amt, span_end));
    in_tdata <= {4'd0, span_end, amt, addr, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Same as send_cmd, but also checks the prediction against a hand value.
  task automatic send_known(logic [2:0] cmd, logic [11:0] addr, logic [31:0] amt,
                            logic [12:0] span_end, result_t known);
    send_cmd(cmd, addr, amt, span_end);
    if (expected_q[$] !== known) begin
      mismatches++;
      if (mismatches <= 10)
        $display("model disagrees with table: cmd %0d addr %0d exp %h got %h",
                 cmd, addr, known, expected_q[$]);
    end
  endtask

  task automatic drain_and_config(int unsigned value);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 13'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    m_blocks = (value > NBLK) ? NBLK : value;
  endtask

  // Result checker.
  always @(posedge clk) begin
    result_t act, exp;
    if (rst_n && out_tvalid && out_tready) begin
      act.status     = out_tdata[1:0];
      act.count      = out_tdata[33:2];
      act.found      = out_tdata[34];
      act.free_block = out_tdata[46:35];
      act.free_total = out_tdata[59:47];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", act);
      end else begin
        exp = expected_q.pop_front();
        if (act.status !== exp.status || act.count !== exp.count ||
            act.found !== exp.found || act.free_block !== exp.free_block ||
            act.free_total !== exp.free_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d cnt=%0d f=%0d fb=%0d ft=%0d, ",
                      "got st=%0d cnt=%0d f=%0d fb=%0d ft=%0d"},
                     exp.status, exp.count, exp.found, exp.free_block, exp.free_total,
                     act.status, act.count, act.found, act.free_block, act.free_total);
        end
      end
    end
  end

  // Receiver back-pressure, with a single long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= out_idle_pct);
    end
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  typedef struct {
    logic [2:0]  cmd;
    logic [11:0] addr;
    logic [31:0] amt;
    logic [12:0] span_end;
    bit          has_known;
    result_t     known;
  } row_t;

  initial begin
    row_t rows[$];
    logic [2:0] cmd;
    logic [11:0] addr;
    logic [31:0] amt;
    logic [12:0] span_end;
    int unsigned sel, lim;
    for (int i = 0; i < NBLK; i++) m_code[i] = 2'd0;
    for (int i = 0; i < OVF_DEPTH; i++) begin
      m_ovf_vld[i] = 1'b0;
      m_ovf_key[i] = '0;
      m_ovf_cnt[i] = '0;
    end
    m_used = 0;
    m_floor = 0;
    m_blocks = NBLK;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; hand values only where they are obvious.
    rows = '{
      '{CMD_GET, 12'd0, 32'd0, 13'd0, 1, '{ST_OK, 32'd0, 1'b0, 12'd0, 13'd4096}},
      '{CMD_GET, 12'd4095, 32'd0, 13'd0, 1, '{ST_OK, 32'd0, 1'b0, 12'd0, 13'd4096}},
      '{CMD_FIND, 12'd0, 32'd0, 13'd4096, 1, '{ST_OK, 32'd0, 1'b1, 12'd0, 13'd4096}},
      '{CMD_SET, 12'd0, 32'hFFFF_FFFF, 13'd0, 1,
        '{ST_OK, 32'hFFFF_FFFF, 1'b0, 12'd0, 13'd4095}},
      '{CMD_INC, 12'd0, 32'd1, 13'd0, 1, '{ST_OK, 32'd0, 1'b0, 12'd0, 13'd4096}},
      '{CMD_DEC, 12'd0, 32'd1, 13'd0, 0, '0},
      '{CMD_INC, 12'd4095, 32'd2, 13'd0, 0, '0},
      '{CMD_INC, 12'd4095, 32'd1, 13'd0, 0, '0},
      '{CMD_DEC, 12'd4095, 32'd2, 13'd0, 0, '0},
      '{CMD_SET, 12'd1, 32'd5, 13'd0, 0, '0},
      '{CMD_FIND, 12'd0, 32'd0, 13'd4096, 0, '0},
      '{CMD_FIND, 12'd5, 32'd0, 13'd5, 1, '{ST_OK, 32'd0, 1'b0, 12'd0, 13'd4093}},
      '{CMD_SET, 12'd0, 32'd0, 13'd0, 0, '0},
      '{CMD_FIND, 12'd0, 32'd0, 13'd8191, 0, '0},
      '{3'd5, 12'd7, 32'd9, 13'd1, 1, '{ST_OK, 32'd0, 1'b0, 12'd0, 13'd4094}},
      '{3'd7, 12'hFFF, 32'hFFFF_FFFF, 13'h1FFF, 0, '0},
      '{CMD_DEC, 12'd2, 32'd3, 13'd0, 0, '0},
      '{CMD_GET, 12'd2, 32'd0, 13'd0, 0, '0}
    };
    foreach (rows[i]) begin
      if (rows[i].has_known)
        send_known(rows[i].cmd, rows[i].addr, rows[i].amt, rows[i].span_end, rows[i].known);
      else
        send_cmd(rows[i].cmd, rows[i].addr, rows[i].amt, rows[i].span_end);
    end

    // Out-of-bounds checks with a small block count.
    drain_and_config(16);
    send_known(CMD_GET, 12'd16, 32'd0, 13'd0, '{ST_BOUNDS, 32'd0, 1'b0, 12'd0, 13'd13});
    send_cmd(CMD_FIND, 12'd3, 32'd0, 13'd100);
    send_cmd(CMD_SET, 12'd15, 32'd1, 13'd0);
    drain_and_config(0);
    send_known(CMD_SET, 12'd0, 32'd1, 13'd0, '{ST_BOUNDS, 32'd0, 1'b0, 12'd0, 13'd0});
    drain_and_config(8191);

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
      out_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 37 : 0;
      if (phase == 1) drain_and_config(200);
      if (phase == 2) drain_and_config(4096);
      lim = (phase == 1) ? 200 : 4096;
      for (int n = 0; n < 700; n++) begin
        if (phase == 2 && n == 50) hold_cycles = 400;
        sel = $urandom_range(99, 0);
        // Mostly a small hot set so counts climb and the overflow table fills.
        addr = (sel < 80) ? 12'($urandom_range(95, 0)) : 12'($urandom_range(4095, 0));
        if (sel < 3 && lim < 4096) addr = 12'($urandom_range(lim + 40, lim - 5));
        sel = $urandom_range(99, 0);
        if (sel < 15) cmd = CMD_GET;
        else if (sel < 30) cmd = CMD_SET;
        else if (sel < 55) cmd = CMD_INC;
        else if (sel < 80) cmd = CMD_DEC;
        else if (sel < 97) cmd = CMD_FIND;
        else cmd = 3'($urandom_range(7, 5));
        sel = $urandom_range(9, 0);
        amt = (sel < 6) ? 32'($urandom_range(4, 0)) :
              (sel < 9) ? $urandom() : 32'hFFFF_FFFF - 32'($urandom_range(3, 0));
        // Keep find spans short so the scan stays fast.
        span_end = 13'(addr + $urandom_range(40, 0));
        if ($urandom_range(49, 0) == 0) span_end = 13'($urandom_range(8191, 0));
        send_cmd(cmd, addr, amt, span_end);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/brsm_pkg.sv
rtl/brsm_ram.sv
rtl/block_refcount_space_map.sv
tb/tb_top.sv
